>>> hw/rtl/hrf_pkg.sv
package hrf_pkg;

	// register map of the write port
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_LAT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_LON = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_MM  = 2'd2;

	localparam int LAT_W  = 31;
	localparam int LON_W  = 32;
	localparam int DIST_W = 35;

	// cordic datapath: x/y in q40 with headroom, angles in q60
	localparam int XY_W    = 44;
	localparam int ANG_W   = 63;
	localparam int UNIT_W  = 41;
	localparam int RAD_W   = 82;
	localparam int REM_W   = 44;
	localparam int SQ_STEPS = 41;

	localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C235;
	localparam logic [63:0] RAD_K_FULL  = (PI_Q62 + 64'd900000000) / 64'd1800000000;
	localparam logic [32:0] RAD_K       = RAD_K_FULL[32:0];
	localparam logic signed [XY_W-1:0] INVK_Q40 = 44'sd667681663043;
	localparam logic [40:0] ONE_Q40     = 41'h100_0000_0000;
	localparam logic [63:0] ZMAX_FULL   = PI_Q62 >> 3;
	localparam logic [60:0] ZMAX        = ZMAX_FULL[60:0];
	localparam logic [33:0] EARTH_DIAM_MM = 34'd12742000000;
	localparam logic [DIST_W-1:0] MARGIN_MM = 35'd1000;
	localparam logic signed [LAT_W-1:0] LAT_LIM = 31'sd900000000;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [UNIT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic              inside_res;
		logic [DIST_W-1:0] distance_mm;
	} res_t;

	// shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in q60, series evaluated in q62
	function automatic logic [ANG_W-1:0] atan_q60(input int i);
		logic [63:0] v;
		logic [63:0] term;
		logic [63:0] v2;
		int e;
		if (i == 0) begin
			v = PI_Q62 >> 2;
		end else begin
			v = '0;
			for (int k = 0; k < 32; k++) begin
				e = 62 - i * (2 * k + 1);
				if (e >= 0) begin
					term = udiv64(64'd1 << e, 64'(2 * k + 1));
					if (k % 2 == 1) v = v - term;
					else v = v + term;
				end
			end
		end
		v2 = (v + 64'd2) >> 2;
		return v2[ANG_W-1:0];
	endfunction

endpackage

>>> hw/rtl/hrf_node_if.sv
interface hrf_node_if;
	logic                              valid;
	logic                              ready;
	logic signed [hrf_pkg::LAT_W-1:0]  node_lat;
	logic signed [hrf_pkg::LON_W-1:0]  node_lon;

	modport source (output valid, output node_lat, output node_lon, input ready);
	modport sink (input valid, input node_lat, input node_lon, output ready);
endinterface

>>> hw/rtl/hrf_res_if.sv
interface hrf_res_if;
	logic                        valid;
	logic                        ready;
	logic                        inside_res;
	logic [hrf_pkg::DIST_W-1:0]  distance_mm;

	modport source (output valid, output inside_res, output distance_mm, input ready);
	modport sink (input valid, input inside_res, input distance_mm, output ready);
endinterface

>>> hw/rtl/hrf_cordic_cell.sv
module hrf_cordic_cell #(
	parameter bit VECT = 1'b0,
	parameter int IDX  = 0
) (
	input  logic             clk,
	input  logic             en,
	input  hrf_pkg::cordic_t d_i,
	output hrf_pkg::cordic_t d_o
);
	localparam logic signed [hrf_pkg::ANG_W-1:0] ANGLE = hrf_pkg::atan_q60(IDX);

	logic signed [hrf_pkg::XY_W-1:0] dx, dy;
	logic                            dir;
	hrf_pkg::cordic_t                nxt;

	always_comb begin
		dx  = d_i.y >>> IDX;
		dy  = d_i.x >>> IDX;
		// rotation follows the angle sign, vectoring drives y to zero
		dir = VECT ? ~d_i.y[hrf_pkg::XY_W-1] : ~d_i.z[hrf_pkg::ANG_W-1];
		if (dir ^ VECT) begin
			nxt.x = d_i.x - dx;
			nxt.y = d_i.y + dy;
			nxt.z = d_i.z - ANGLE;
		end else begin
			nxt.x = d_i.x + dx;
			nxt.y = d_i.y - dy;
			nxt.z = d_i.z + ANGLE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) d_o <= nxt;
	end
endmodule

>>> hw/rtl/hrf_sqrt_cell.sv
module hrf_sqrt_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  hrf_pkg::sqrt_t d_i,
	output hrf_pkg::sqrt_t d_o
);
	logic [hrf_pkg::REM_W-1:0] rem_n, trial;
	logic                      ge;
	hrf_pkg::sqrt_t            nxt;

	always_comb begin
		rem_n = {d_i.rem[hrf_pkg::REM_W-3:0], d_i.rad[2*IDX+1 -: 2]};
		trial = {1'b0, d_i.root, 2'b01};
		ge    = rem_n >= trial;
		nxt.rad  = d_i.rad;
		nxt.rem  = ge ? rem_n - trial : rem_n;
		nxt.root = {d_i.root[hrf_pkg::UNIT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) d_o <= nxt;
	end
endmodule

>>> hw/rtl/hrf_mul.sv
module hrf_mul #(
	parameter int AW = 41,
	parameter int BW = 41
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);
	localparam int LO = (AW + 1) / 2;
	localparam int HI = AW - LO;

	logic [LO+BW-1:0] pl_s1;
	logic [HI+BW-1:0] ph_s1;

	// two partial products, then one wide add
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= (LO+BW)'(a[LO-1:0]) * (LO+BW)'(b);
			ph_s1 <= (HI+BW)'(a[AW-1:LO]) * (HI+BW)'(b);
			p     <= ((AW+BW)'(ph_s1) << LO) + (AW+BW)'(pl_s1);
		end
	end
endmodule

>>> hw/rtl/haversine_radius_filter.sv
// channel | dir | beat contents
// node    | in  | node_lat (31b signed), node_lon (32b signed), 1e-7 degree
// res     | out | inside_res (1b), distance_mm (35b)
// wr_*    | in  | register write: center_lat, center_lon, radius_mm
//
// one node beat accepted per cycle while no skid beat is held; each gives one
// result beat through the two cordic chains and the 41-cell sqrt chain.
// reset clears the valid flags (pipeline, output, skid) and the registers.
// a stalled res channel fills the skid beat, then holds the whole pipeline
module haversine_radius_filter #(
	parameter int CORDIC_STEPS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	hrf_node_if.sink                          node,
	hrf_res_if.source                         res,
	input  logic                              wr_en,
	input  logic [hrf_pkg::REG_IDX_W-1:0]     wr_idx,
	input  logic [hrf_pkg::DIST_W-1:0]        wr_data
);
	localparam int LAT = 2 * CORDIC_STEPS + 57;
	localparam int XW  = hrf_pkg::XY_W;
	localparam int AW  = hrf_pkg::ANG_W;
	localparam int UW  = hrf_pkg::UNIT_W;

	// configuration
	logic signed [30:0]          clat_q;
	logic signed [31:0]          clon_q;
	logic [hrf_pkg::DIST_W-1:0]  radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clat_q   <= '0;
			clon_q   <= '0;
			radius_q <= '0;
		end else if (wr_en) begin
			unique case (wr_idx)
				hrf_pkg::REG_CENTER_LAT: clat_q   <= wr_data[30:0];
				hrf_pkg::REG_CENTER_LON: clon_q   <= wr_data[31:0];
				hrf_pkg::REG_RADIUS_MM:  radius_q <= wr_data;
				default: ;
			endcase
		end
	end

	// flow control: whole pipeline advances unless the skid beat is held
	logic           en;
	logic [LAT-1:0] vld_q;
	logic           fin_v;
	logic           out_v_q, skid_v_q;
	hrf_pkg::res_t  fin_s, out_q, skid_q;

	assign en         = !skid_v_q;
	assign node.ready = en;
	assign fin_v      = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], node.valid};
	end

	function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
		if (v > hrf_pkg::LAT_LIM) return hrf_pkg::LAT_LIM;
		if (v < -hrf_pkg::LAT_LIM) return -hrf_pkg::LAT_LIM;
		return v;
	endfunction

	function automatic logic [UW-1:0] clamp_unit(input logic signed [XW-1:0] v);
		if (v < 0) return '0;
		if (v > $signed({3'b0, hrf_pkg::ONE_Q40})) return hrf_pkg::ONE_Q40;
		return v[UW-1:0];
	endfunction

	// stage 1: clamp latitudes, raw longitude difference
	logic signed [30:0] nlat_s1, clat_s1;
	logic signed [32:0] dlon_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nlat_s1 <= clamp_lat(node.node_lat);
			clat_s1 <= clamp_lat(clat_q);
			dlon_s1 <= {node.node_lon[31], node.node_lon} - {clon_q[31], clon_q};
		end
	end

	// stage 2: absolute differences and latitudes, longitude wrapped into half a turn
	logic signed [31:0] dlat;
	logic signed [33:0] dlon_x, dlon_w, dlon_a;
	logic [30:0]        dlat_s2, dlon_s2, calat_s2, nalat_s2;

	always_comb begin
		dlat   = {nlat_s1[30], nlat_s1} - {clat_s1[30], clat_s1};
		dlon_x = {dlon_s1[32], dlon_s1};
		if (dlon_x > 34'sd1800000000) dlon_w = dlon_x - 34'sd3600000000;
		else if (dlon_x < -34'sd1800000000) dlon_w = dlon_x + 34'sd3600000000;
		else dlon_w = dlon_x;
		dlon_a = (dlon_w < 0) ? -dlon_w : dlon_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s2  <= dlat[31] ? 31'(-dlat) : dlat[30:0];
			dlon_s2  <= dlon_a[30:0];
			calat_s2 <= clat_s1[30] ? 31'(-clat_s1) : clat_s1;
			nalat_s2 <= nlat_s1[30] ? 31'(-nlat_s1) : nlat_s1;
		end
	end

	// degrees to radians: lanes are dlat/2, dlon/2, center lat, node lat
	logic [30:0] units [4];
	logic [63:0] rad_p [4];
	assign units[0] = dlat_s2;
	assign units[1] = dlon_s2;
	assign units[2] = calat_s2;
	assign units[3] = nalat_s2;

	hrf_pkg::cordic_t rot_w [4][CORDIC_STEPS+1];

	for (genvar l = 0; l < 4; l++) begin : g_rot
		hrf_mul #(.AW(31), .BW(33)) u_rad (
			.clk(clk), .en(en), .a(units[l]), .b(hrf_pkg::RAD_K), .p(rad_p[l])
		);
		// half angles drop one more bit
		assign rot_w[l][0].x = hrf_pkg::INVK_Q40;
		assign rot_w[l][0].y = '0;
		assign rot_w[l][0].z = (l < 2) ? {2'b0, rad_p[l][63:3]} : {1'b0, rad_p[l][63:2]};
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
			hrf_cordic_cell #(.VECT(1'b0), .IDX(i)) u_cell (
				.clk(clk), .en(en), .d_i(rot_w[l][i]), .d_o(rot_w[l][i+1])
			);
		end
	end

	// clamp sin/cos into [0, 1]
	logic [UW-1:0] s1_s3, s2_s3, c1_s3, c2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s3 <= clamp_unit(rot_w[0][CORDIC_STEPS].y);
			s2_s3 <= clamp_unit(rot_w[1][CORDIC_STEPS].y);
			c1_s3 <= clamp_unit(rot_w[2][CORDIC_STEPS].x);
			c2_s3 <= clamp_unit(rot_w[3][CORDIC_STEPS].x);
		end
	end

	// t = s2*c1, u = s2*c2, s1^2
	logic [2*UW-1:0] t_p, u_p, sq_p, tu_p;
	logic [2*UW-1:0] sq_s6, sq_s7;

	hrf_mul #(.AW(UW), .BW(UW)) u_mul_t (
		.clk(clk), .en(en), .a(s2_s3), .b(c1_s3), .p(t_p)
	);
	hrf_mul #(.AW(UW), .BW(UW)) u_mul_u (
		.clk(clk), .en(en), .a(s2_s3), .b(c2_s3), .p(u_p)
	);
	hrf_mul #(.AW(UW), .BW(UW)) u_mul_sq (
		.clk(clk), .en(en), .a(s1_s3), .b(s1_s3), .p(sq_p)
	);
	hrf_mul #(.AW(UW), .BW(UW)) u_mul_tu (
		.clk(clk), .en(en), .a(t_p[80:40]), .b(u_p[80:40]), .p(tu_p)
	);

	// s1^2 waits for t*u
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6 <= sq_p;
			sq_s7 <= sq_s6;
		end
	end

	// a = s1^2 + t*u clamped to one, and its complement
	logic [81:0] asum_s8;
	logic [80:0] a_s9, ac_s9;
	logic [80:0] a_cl;

	assign a_cl = (asum_s8 > 82'(81'h1_0000_0000_0000_0000_0000)) ?
		81'h1_0000_0000_0000_0000_0000 : asum_s8[80:0];

	always_ff @(posedge clk) begin
		if (en) begin
			asum_s8 <= sq_s7 + tu_p;
			a_s9    <= a_cl;
			ac_s9   <= 81'h1_0000_0000_0000_0000_0000 - a_cl;
		end
	end

	// h = sqrt(a), q = sqrt(1 - a), one root bit per cell
	hrf_pkg::sqrt_t sq_w [2][hrf_pkg::SQ_STEPS+1];

	assign sq_w[0][0].rad  = {1'b0, a_s9};
	assign sq_w[1][0].rad  = {1'b0, ac_s9};
	assign sq_w[0][0].rem  = '0;
	assign sq_w[1][0].rem  = '0;
	assign sq_w[0][0].root = '0;
	assign sq_w[1][0].root = '0;

	for (genvar l = 0; l < 2; l++) begin : g_sqrt
		for (genvar j = 0; j < hrf_pkg::SQ_STEPS; j++) begin : g_bit
			hrf_sqrt_cell #(.IDX(hrf_pkg::SQ_STEPS - 1 - j)) u_cell (
				.clk(clk), .en(en), .d_i(sq_w[l][j]), .d_o(sq_w[l][j+1])
			);
		end
	end

	// asin(h) as atan2(h, q) by vectoring
	hrf_pkg::cordic_t vec_w [CORDIC_STEPS+1];

	assign vec_w[0].x = {3'b0, sq_w[1][hrf_pkg::SQ_STEPS].root};
	assign vec_w[0].y = {3'b0, sq_w[0][hrf_pkg::SQ_STEPS].root};
	assign vec_w[0].z = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		hrf_cordic_cell #(.VECT(1'b1), .IDX(i)) u_cell (
			.clk(clk), .en(en), .d_i(vec_w[i]), .d_o(vec_w[i+1])
		);
	end

	// clamp the angle into [0, pi/2] and scale by the earth diameter
	logic signed [AW-1:0] zv;
	logic [60:0]          z_s10;
	logic [94:0]          dist_p;
	logic [95:0]          dist_r;
	logic [hrf_pkg::DIST_W-1:0] dist_s13;

	assign zv = vec_w[CORDIC_STEPS].z;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zv < 0) z_s10 <= '0;
			else if (zv > $signed({2'b0, hrf_pkg::ZMAX})) z_s10 <= hrf_pkg::ZMAX;
			else z_s10 <= zv[60:0];
		end
	end

	hrf_mul #(.AW(61), .BW(34)) u_mul_dist (
		.clk(clk), .en(en), .a(z_s10), .b(hrf_pkg::EARTH_DIAM_MM), .p(dist_p)
	);

	// round to nearest mm
	assign dist_r = {1'b0, dist_p} + (96'd1 << 59);

	always_ff @(posedge clk) begin
		if (en) dist_s13 <= dist_r[94:60];
	end

	// radius test
	always_ff @(posedge clk) begin
		if (en) begin
			fin_s.inside_res  <= (dist_s13 < radius_q) && (dist_s13 > hrf_pkg::MARGIN_MM);
			fin_s.distance_mm <= dist_s13;
		end
	end

	// output register with one skid beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || res.ready) begin
			out_v_q  <= skid_v_q | fin_v;
			skid_v_q <= 1'b0;
		end else if (en && fin_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res.ready) out_q <= skid_v_q ? skid_q : fin_s;
		else if (en && fin_v) skid_q <= fin_s;
	end

	assign res.valid       = out_v_q;
	assign res.inside_res  = out_q.inside_res;
	assign res.distance_mm = out_q.distance_mm;

`ifndef SYNTHESIS
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid beat without output beat");
	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_v && en && out_v_q && !res.ready) |=> skid_v_q)
		else $error("finished beat dropped on stall");
	a_flag_margin: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.inside_res) |-> (res.distance_mm > hrf_pkg::MARGIN_MM))
		else $error("flag set inside safety margin");
`endif
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	// widths taken from the package
	localparam int REG_IDX_W = hrf_pkg::REG_IDX_W;
	localparam int LAT_W     = hrf_pkg::LAT_W;
	localparam int LON_W     = hrf_pkg::LON_W;
	localparam int DIST_W    = hrf_pkg::DIST_W;

	// unused code of the two-bit register index, writes to it must be dropped
	localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;

	// pipeline depth of the filter, plus margin for the skid stage
	localparam int PIPE_LAT = 2 * 32 + 58 + 8;

	// fixed-point constants of the distance math
	localparam longint unsigned PI_Q62_U = 64'hC90FDAA22168C235;
	localparam longint unsigned UNIT_TO_RAD = (PI_Q62_U + 64'd900000000) / 64'd1800000000;
	localparam longint signed   CORDIC_GAIN_INV = 64'sd667681663043;
	localparam longint signed   UNIT_Q40 = 64'd1 << 40;
	localparam longint signed   LAT_MAX = 64'sd900000000;
	localparam longint signed   HALF_TURN = 64'sd1800000000;
	localparam longint signed   FULL_TURN = 64'sd3600000000;
	localparam int              ROT_STEPS = 32;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_idx;
	logic [DIST_W-1:0] wr_data;

	hrf_node_if node_if ();
	hrf_res_if res_if ();

	haversine_radius_filter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.node    (node_if.sink),
		.res     (res_if.source),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	// shadow copy of the register file
	logic [LAT_W-1:0]  cen_lat;
	logic [LON_W-1:0]  cen_lon;
	logic [DIST_W-1:0] radius;

	longint signed atan_tab [ROT_STEPS];
	hrf_pkg::res_t dist_expect_q [$];

	int errors;
	int nodes_sent;
	int results_seen;
	int inside_seen;
	bit node_gaps;
	bit res_stalls;
	int hold_left;
	int stall_left;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// safety net: far beyond the slowest legal run
	initial begin
		#5ms;
		$display("timeout with %0d beats still expected", dist_expect_q.size());
		$display("== FAIL ==");
		$finish;
	end

	// atan(2^-i) in q60, from the arctangent series evaluated in q62
	function automatic longint signed atan_step(input int i);
		longint unsigned acc;
		longint unsigned term;
		longint unsigned one;
		longint unsigned div;
		int e;
		one = 1;
		if (i == 0) begin
			acc = PI_Q62_U >> 2;
		end else begin
			acc = 0;
			for (int k = 0; k < 64; k++) begin
				e = 62 - i * (2 * k + 1);
				if (e < 0) break;
				div = 2 * k + 1;
				term = (one << e) / div;
				if (k % 2 == 1) acc = acc - term;
				else acc = acc + term;
			end
		end
		return longint'((acc + 2) >> 2);
	endfunction

	function automatic longint signed sat_lat(input longint signed v);
		if (v > LAT_MAX) return LAT_MAX;
		if (v < -LAT_MAX) return -LAT_MAX;
		return v;
	endfunction

	function automatic longint signed sat_unit(input longint signed v);
		if (v < 0) return 0;
		if (v > UNIT_Q40) return UNIT_Q40;
		return v;
	endfunction

	// 1e-7 degree units to q60 radians, optionally halved
	function automatic longint signed units_to_angle(input longint unsigned u, input int halve);
		longint unsigned p;
		p = u * UNIT_TO_RAD;
		return longint'(p >> (2 + halve));
	endfunction

	// rotation-mode cordic, returns cos and sin clamped to [0,1] in q40
	task automatic sincos(input longint signed ang, output longint signed c,
			output longint signed s);
		longint signed x, y, z, dx, dy;
		x = CORDIC_GAIN_INV;
		y = 0;
		z = ang;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		c = sat_unit(x);
		s = sat_unit(y);
	endtask

	// floor square root, one result bit per pair of input bits
	function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
		logic [127:0] r, rem, trial;
		r = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = (rem << 2) | v[2*k +: 2];
			trial = (r << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				r = (r << 1) | 128'd1;
			end else begin
				r = r << 1;
			end
		end
		return r[63:0];
	endfunction

	// vectoring-mode cordic: angle of (x, y), clamped to [0, pi/2]
	function automatic longint signed vec_angle(input longint signed x0, input longint signed y0);
		longint signed x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_tab[i];
			end else begin
				x -= dx; y += dy; z -= atan_tab[i];
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(PI_Q62_U >> 3)) z = longint'(PI_Q62_U >> 3);
		return z;
	endfunction

	// great-circle distance and circle flag for one node under the current registers
	task automatic predict_distance(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
			output hrf_pkg::res_t r);
		longint signed nlat, clat, dlat, dlon, s1, s2, c1, c2, dummy, z;
		logic [127:0] p1, p2, hav, rest, dd;
		logic [63:0] t, u, h, q;
		nlat = sat_lat(longint'($signed(lat)));
		clat = sat_lat(longint'($signed(cen_lat)));
		dlat = nlat - clat;
		if (dlat < 0) dlat = -dlat;
		dlon = longint'($signed(lon)) - longint'($signed(cen_lon));
		if (dlon > HALF_TURN) dlon -= FULL_TURN;
		else if (dlon < -HALF_TURN) dlon += FULL_TURN;
		if (dlon < 0) dlon = -dlon;
		sincos(units_to_angle(dlat, 1), dummy, s1);
		sincos(units_to_angle(dlon, 1), dummy, s2);
		sincos(units_to_angle(clat < 0 ? -clat : clat, 0), c1, dummy);
		sincos(units_to_angle(nlat < 0 ? -nlat : nlat, 0), c2, dummy);
		p1 = {64'd0, s2} * {64'd0, c1};
		t = p1[103:40];
		p2 = {64'd0, s2} * {64'd0, c2};
		u = p2[103:40];
		hav = {64'd0, s1} * {64'd0, s1} + {64'd0, t} * {64'd0, u};
		// rounding can push the haversine term past one
		if (hav > (128'd1 << 80)) hav = 128'd1 << 80;
		rest = (128'd1 << 80) - hav;
		h = floor_sqrt(hav);
		q = floor_sqrt(rest);
		z = vec_angle(longint'(q), longint'(h));
		dd = {64'd0, z} * 128'd12742000000 + (128'd1 << 59);
		r.distance_mm = dd[94:60];
		r.inside_res = (r.distance_mm < radius) && (r.distance_mm > hrf_pkg::MARGIN_MM);
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// result checker, samples at the rising edge
	always @(posedge clk) begin
		hrf_pkg::res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (dist_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, distance %0d", res_if.distance_mm));
			end else begin
				want = dist_expect_q.pop_front();
				if (res_if.inside_res) inside_seen++;
				if (res_if.distance_mm !== want.distance_mm)
					report_mismatch($sformatf("distance_mm got %0d want %0d",
						res_if.distance_mm, want.distance_mm));
				if (res_if.inside_res !== want.inside_res)
					report_mismatch($sformatf("inside_res got %b want %b (distance %0d)",
						res_if.inside_res, want.inside_res, want.distance_mm));
			end
		end
	end

	// result ready: long hold-offs on request, optional random stall bursts, otherwise high
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (res_stalls && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// offer one node beat; valid stays high on exit so back-to-back beats need no toggle
	task automatic send_node(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
		hrf_pkg::res_t want;
		@(negedge clk);
		if (node_gaps && $urandom_range(0, 4) == 0) begin
			node_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		node_if.valid <= 1'b1;
		node_if.node_lat <= lat;
		node_if.node_lon <= lon;
		do @(posedge clk); while (!node_if.ready);
		predict_distance(lat, lon, want);
		dist_expect_q = {dist_expect_q, want};
		nodes_sent++;
	endtask

	task automatic node_idle();
		@(negedge clk);
		node_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		node_idle();
		while (dist_expect_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			hrf_pkg::REG_CENTER_LAT: cen_lat = val[LAT_W-1:0];
			hrf_pkg::REG_CENTER_LON: cen_lon = val[LON_W-1:0];
			hrf_pkg::REG_RADIUS_MM:  radius = val;
			default: ;
		endcase
	endtask

	task automatic set_circle(input longint signed lat, input longint signed lon,
			input longint unsigned rad);
		write_reg(hrf_pkg::REG_CENTER_LAT, DIST_W'(lat));
		write_reg(hrf_pkg::REG_CENTER_LON, DIST_W'(lon));
		write_reg(hrf_pkg::REG_RADIUS_MM, DIST_W'(rad));
	endtask

	// node near the centre at a random scale, or any raw bit pattern
	task automatic send_random_node();
		longint signed span, lat, lon;
		if ($urandom_range(0, 3) == 0) begin
			send_node(LAT_W'($urandom), $urandom);
		end else begin
			case ($urandom_range(0, 3))
				0: span = 100;
				1: span = 100000;
				2: span = 10000000;
				default: span = 600000000;
			endcase
			lat = longint'($signed(cen_lat)) + longint'($urandom_range(0, 2 * span)) - span;
			lon = longint'($signed(cen_lon)) + longint'($urandom_range(0, 2 * span)) - span;
			send_node(LAT_W'(lat), LON_W'(lon));
		end
	endtask

	// registers at reset: centre at the origin, radius zero, so no flag is ever set
	task automatic test_reset_defaults();
		send_node('0, '0);
		send_node(LAT_W'(LAT_MAX), '0);
		send_node(LAT_W'(-LAT_MAX), '0);
		send_node('0, LON_W'(HALF_TURN));
		send_node('0, LON_W'(-HALF_TURN));
		send_node({1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}});
		send_node({1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}});
		send_node('1, '1);
		wait_drained();
	endtask

	// extreme centres, dateline wrap, poles, node on the centre and the 1 m margin
	task automatic test_directed_extremes();
		set_circle(450000000, 1790000000, 64'd20015086795);
		write_reg(REG_NONE, '1);
		send_node(LAT_W'(450000000), LON_W'(1790000000));
		send_node(LAT_W'(450000001), LON_W'(1790000000));
		send_node(LAT_W'(450000000), LON_W'(-1790000000));
		send_node(LAT_W'(-450000000), LON_W'(-10000000));
		send_node(LAT_W'(LAT_MAX), '0);
		send_node(LAT_W'(450000090), LON_W'(1790000000));
		wait_drained();
		set_circle(-LAT_MAX, -HALF_TURN, 64'h7_FFFF_FFFF);
		send_node(LAT_W'(LAT_MAX), LON_W'(HALF_TURN));
		send_node({1'b1, {(LAT_W-1){1'b0}}}, LON_W'(HALF_TURN));
		send_node(LAT_W'(-LAT_MAX + 1000), LON_W'(1234567));
		send_node('0, '0);
		wait_drained();
		set_circle({1'b0, {(LAT_W-1){1'b1}}}, HALF_TURN, 0);
		send_node(LAT_W'(LAT_MAX), LON_W'(-HALF_TURN));
		send_node(LAT_W'(-LAT_MAX), '0);
		wait_drained();
	endtask

	// several random circles with random nodes around them, both sides idling
	task automatic test_random_circles();
		longint signed clat, clon;
		longint unsigned rad;
		node_gaps = 1;
		res_stalls = 1;
		for (int ph = 0; ph < 4; ph++) begin
			clat = longint'($urandom_range(0, 1800000000)) - LAT_MAX;
			clon = longint'($urandom_range(0, 32'd3600000000)) - HALF_TURN;
			case (ph)
				0: rad = $urandom_range(0, 5000);
				1: rad = longint'($urandom_range(0, 2000000)) * 10;
				2: rad = longint'($urandom_range(0, 2000000)) * 10000;
				default: rad = longint'($urandom_range(0, 2000000000)) * 10;
			endcase
			set_circle(clat, clon, rad);
			repeat (200) send_random_node();
			wait_drained();
		end
	endtask

	// receiver stalls for a long stretch while nodes keep coming, then sender pauses, then more nodes under random stalls
	task automatic test_backpressure();
		node_gaps = 0;
		res_stalls = 0;
		set_circle(515000000, -1200000, 64'd50000000);
		@(posedge clk);
		hold_left = 500;
		repeat (150) send_random_node();
		node_idle();
		while (dist_expect_q.size() != 0) @(posedge clk);
		res_stalls = 1;
		repeat (40) send_random_node();
		wait_drained();
	endtask

	// closing stretch at full rate on both sides
	task automatic test_full_rate();
		node_gaps = 0;
		res_stalls = 0;
		set_circle(-338000000, 1512000000, 64'd1000000000);
		repeat (100) send_random_node();
		wait_drained();
	endtask

	initial begin
		errors = 0;
		nodes_sent = 0;
		results_seen = 0;
		inside_seen = 0;
		node_gaps = 0;
		res_stalls = 0;
		hold_left = 0;
		stall_left = 0;
		cen_lat = '0;
		cen_lon = '0;
		radius = '0;
		node_if.valid = 1'b0;
		node_if.node_lat = '0;
		node_if.node_lon = '0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		for (int i = 0; i < ROT_STEPS; i++) atan_tab[i] = atan_step(i);
		@(posedge arst_n);
		test_reset_defaults();
		test_directed_extremes();
		test_random_circles();
		test_backpressure();
		test_full_rate();
		if (dist_expect_q.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", dist_expect_q.size()));
		$display("covered %0d nodes, %0d results (%0d inside) over 10 circle settings",
			nodes_sent, results_seen, inside_seen);
		$display("with gaps, stall bursts, a long result hold-off and full-rate streaming");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/hrf_pkg.sv
hw/rtl/hrf_node_if.sv
hw/rtl/hrf_res_if.sv
hw/rtl/hrf_cordic_cell.sv
hw/rtl/hrf_sqrt_cell.sv
hw/rtl/hrf_mul.sv
hw/rtl/haversine_radius_filter.sv
tb/tb_top.sv
